// ===== src/tbcc_pkg.sv =====
// Shared types, constants and calendar helpers for the tick-based calendar clock.
// Depends on nothing; every other file imports it.
`default_nettype none

package tbcc_pkg;

	// width of a quotient out of the constant divider (elapsed seconds fit in 23 bits)
	localparam int unsigned QUO_W = 23;
	localparam int unsigned DAY_W = 9;

	// reciprocal multipliers: floor(x / k) == (x * MAG_k) >> SH_k for every 32-bit x
	localparam logic [31:0] MAG_1000 = 32'h1062_4DD3;
	localparam logic [31:0] MAG_60   = 32'h8888_8889;
	localparam logic [31:0] MAG_24   = 32'hAAAA_AAAB;
	localparam int unsigned SH_1000 = 38;
	localparam int unsigned SH_60   = 37;
	localparam int unsigned SH_24   = 36;

	// 25 * INV25 == 1 mod 2^16, so y is a multiple of 25 iff y * INV25 mod 2^16 <= 65535 / 25
	localparam logic [15:0] INV25       = 16'd23593;
	localparam logic [15:0] DIV25_LIMIT = 16'd2621;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SYNC,
		OP_MUL,
		OP_DIV,
		OP_LOAD_SEC,
		OP_SPLIT_SEC,
		OP_SPLIT_MIN,
		OP_SPLIT_HR,
		OP_MONTH,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [1:0] {
		DIV_BY_1000,
		DIV_BY_60,
		DIV_BY_24
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_MS,
		ST_LOAD_SEC,
		ST_DIV_SEC,
		ST_SPLIT_SEC,
		ST_DIV_MIN,
		ST_SPLIT_MIN,
		ST_DIV_HR,
		ST_SPLIT_HR,
		ST_WALK,
		ST_PUB
	} ctl_state_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic synced;
		logic month_fit;
	} dp_stat_t;

	function automatic logic is_leap(input logic [15:0] y);
		logic [31:0] p;
		logic        div4;
		logic        div16;
		logic        div25;
		p     = {16'd0, y} * {16'd0, INV25};
		div4  = (y[1:0] == 2'd0);
		div16 = (y[3:0] == 4'd0);
		div25 = (p[15:0] <= DIV25_LIMIT);
		// multiple of 100 is 4 and 25, multiple of 400 is 16 and 25
		return (div4 && !div25) || (div16 && div25);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== src/tick_based_calendar_clock.sv =====
// Tick-based calendar clock: a sync item stores a date, a time and the tick count at
// which they held; a query item returns the calendar date and time at its own tick.
// A sync gives no result; a sync whose month is not 1..12 is dropped. A query before
// any sync returns valid_res = 0 with all fields zero. A synced query scales the tick
// difference, then a shared reciprocal-multiply divider splits milliseconds, seconds,
// minutes and hours, each step a divide state and then a load or split state, and the
// month walk retires one month per cycle; it crosses at most 10 month ends, since a
// base day of up to 255 plus at most 60 carried days stays below 316. The finished
// item sits in an output register, so the block takes the next item while the
// result still waits to be taken.
`default_nettype none

module tick_based_calendar_clock import tbcc_pkg::*; #(
	parameter int unsigned TICK_PERIOD_MS = 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        command,
	input  wire logic [15:0] year,
	input  wire logic [3:0]  month,
	input  wire logic [7:0]  day,
	input  wire logic [7:0]  hour,
	input  wire logic [7:0]  minute,
	input  wire logic [7:0]  second,
	input  wire logic [31:0] tick_now,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        valid_res,
	output      logic [15:0] out_year,
	output      logic [3:0]  out_month,
	output      logic [4:0]  out_day,
	output      logic [4:0]  out_hour,
	output      logic [5:0]  out_minute,
	output      logic [5:0]  out_second
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tbcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tbcc_dp #(
		.TICK_PERIOD_MS(TICK_PERIOD_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second),
		.tick_now  (tick_now),
		.valid_res (valid_res),
		.out_year  (out_year),
		.out_month (out_month),
		.out_day   (out_day),
		.out_hour  (out_hour),
		.out_minute(out_minute),
		.out_second(out_second)
	);

	// a query keeps the input side closed until its result is published
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command) |=> in_stall)
		else $error("input taken while a query is in flight");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PUBLISH) |=> out_valid)
		else $error("published result not presented");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res) |-> (out_month >= 4'd1 && out_month <= 4'd12))
		else $error("result month out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && valid_res) |->
		(out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60))
		else $error("result time of day out of range");

endmodule

`default_nettype wire

// ===== src/tbcc_dp.sv =====
// Datapath of the calendar clock: base registers, constant divider, month walk
// and result registers. Driven by tbcc_ctrl through dp_cmd_t; uses tbcc_pkg.
`default_nettype none

module tbcc_dp import tbcc_pkg::*; #(
	parameter int unsigned TICK_PERIOD_MS = 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output      dp_stat_t    stat,
	input  wire logic [15:0] year,
	input  wire logic [3:0]  month,
	input  wire logic [7:0]  day,
	input  wire logic [7:0]  hour,
	input  wire logic [7:0]  minute,
	input  wire logic [7:0]  second,
	input  wire logic [31:0] tick_now,
	output      logic        valid_res,
	output      logic [15:0] out_year,
	output      logic [3:0]  out_month,
	output      logic [4:0]  out_day,
	output      logic [4:0]  out_hour,
	output      logic [5:0]  out_minute,
	output      logic [5:0]  out_second
);

	localparam int unsigned PW = $clog2(TICK_PERIOD_MS + 1);

	logic [PW-1:0] period_c;

	logic [15:0] base_year_q;
	logic [3:0]  base_month_q;
	logic [7:0]  base_day_q;
	logic [7:0]  base_hour_q;
	logic [7:0]  base_minute_q;
	logic [7:0]  base_second_q;
	logic [31:0] base_tick_q;
	logic        synced_q;

	logic [31:0]      acc_q;
	logic [QUO_W-1:0] quo_q;
	logic [5:0]       sec_q;
	logic [5:0]       min_q;
	logic [4:0]       hr_q;
	logic [DAY_W-1:0] d_q;
	logic [3:0]       m_q;
	logic [15:0]      y_q;

	logic              valid_res_q;
	logic [15:0]       out_year_q;
	logic [3:0]        out_month_q;
	logic [4:0]        out_day_q;
	logic [4:0]        out_hour_q;
	logic [5:0]        out_minute_q;
	logic [5:0]        out_second_q;

	logic [31:0]      diff;
	logic [31+PW:0]   mul_full;
	logic [31:0]      magic;
	logic [63:0]      mag_prod;
	logic [QUO_W-1:0] quo_next;
	logic [31:0]      rem60;
	logic [31:0]      rem24;
	logic [4:0]       mlen;
	logic             month_fit;
	logic             mon_ok;
	logic [3:0]       m_start;

	assign period_c = PW'(TICK_PERIOD_MS);

	always_comb begin
		diff     = tick_now - base_tick_q;
		mul_full = diff * period_c;
		case (cmd.div_sel)
			DIV_BY_60: begin
				magic = MAG_60;
			end
			DIV_BY_24: begin
				magic = MAG_24;
			end
			default: begin
				magic = MAG_1000;
			end
		endcase
		mag_prod = {32'd0, acc_q} * {32'd0, magic};
		case (cmd.div_sel)
			DIV_BY_60: begin
				quo_next = mag_prod[SH_60 +: QUO_W];
			end
			DIV_BY_24: begin
				quo_next = mag_prod[SH_24 +: QUO_W];
			end
			default: begin
				quo_next = mag_prod[SH_1000 +: QUO_W];
			end
		endcase
		rem60     = acc_q - ({9'd0, quo_q} * 32'd60);
		rem24     = acc_q - ({9'd0, quo_q} * 32'd24);
		mlen      = month_days(m_q, is_leap(y_q));
		month_fit = (d_q <= {4'd0, mlen});
		mon_ok    = (month != 4'd0) && (month <= 4'd12);
		m_start   = ((base_month_q != 4'd0) && (base_month_q <= 4'd12)) ? base_month_q : 4'd1;
	end

	assign stat.synced    = synced_q;
	assign stat.month_fit = month_fit;

	// base of the wall clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q   <= '0;
			base_month_q  <= '0;
			base_day_q    <= '0;
			base_hour_q   <= '0;
			base_minute_q <= '0;
			base_second_q <= '0;
			base_tick_q   <= '0;
			synced_q      <= 1'b0;
		end else if (cmd.op == OP_SYNC && mon_ok) begin
			base_year_q   <= year;
			base_month_q  <= month;
			base_day_q    <= day;
			base_hour_q   <= hour;
			base_minute_q <= minute;
			base_second_q <= second;
			base_tick_q   <= tick_now;
			synced_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MUL: begin
				acc_q <= mul_full[31:0];
			end
			OP_DIV: begin
				quo_q <= quo_next;
			end
			OP_LOAD_SEC: begin
				acc_q <= {24'd0, base_second_q} + {9'd0, quo_q};
			end
			OP_SPLIT_SEC: begin
				sec_q <= rem60[5:0];
				acc_q <= {24'd0, base_minute_q} + {9'd0, quo_q};
			end
			OP_SPLIT_MIN: begin
				min_q <= rem60[5:0];
				acc_q <= {24'd0, base_hour_q} + {9'd0, quo_q};
			end
			OP_SPLIT_HR: begin
				hr_q <= rem24[4:0];
				d_q  <= {1'b0, base_day_q} + quo_q[DAY_W-1:0];
				m_q  <= m_start;
				y_q  <= base_year_q;
			end
			OP_MONTH: begin
				if (!month_fit) begin
					d_q <= d_q - {4'd0, mlen};
					if (m_q == 4'd12) begin
						m_q <= 4'd1;
						y_q <= y_q + 16'd1;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result register, held while the output side stalls
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			valid_res_q  <= synced_q;
			out_year_q   <= synced_q ? y_q : 16'd0;
			out_month_q  <= synced_q ? m_q : 4'd0;
			out_day_q    <= synced_q ? d_q[4:0] : 5'd0;
			out_hour_q   <= synced_q ? hr_q : 5'd0;
			out_minute_q <= synced_q ? min_q : 6'd0;
			out_second_q <= synced_q ? sec_q : 6'd0;
		end
	end

	assign valid_res  = valid_res_q;
	assign out_year   = out_year_q;
	assign out_month  = out_month_q;
	assign out_day    = out_day_q;
	assign out_hour   = out_hour_q;
	assign out_minute = out_minute_q;
	assign out_second = out_second_q;

endmodule

`default_nettype wire

// ===== src/tbcc_ctrl.sv =====
// Controller of the calendar clock: sequences one query through the datapath
// and owns both handshakes. Uses tbcc_pkg.
`default_nettype none

module tbcc_ctrl import tbcc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_stall,
	input  wire logic     command,
	output      logic     out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output      dp_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !command) begin
					state_next = stat.synced ? ST_DIV_MS : ST_PUB;
				end
			end
			ST_DIV_MS: begin
				state_next = ST_LOAD_SEC;
			end
			ST_LOAD_SEC: begin
				state_next = ST_DIV_SEC;
			end
			ST_DIV_SEC: begin
				state_next = ST_SPLIT_SEC;
			end
			ST_SPLIT_SEC: begin
				state_next = ST_DIV_MIN;
			end
			ST_DIV_MIN: begin
				state_next = ST_SPLIT_MIN;
			end
			ST_SPLIT_MIN: begin
				state_next = ST_DIV_HR;
			end
			ST_DIV_HR: begin
				state_next = ST_SPLIT_HR;
			end
			ST_SPLIT_HR: begin
				state_next = ST_WALK;
			end
			ST_WALK: begin
				if (stat.month_fit) begin
					state_next = ST_PUB;
				end
			end
			ST_PUB: begin
				if (slot_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op      = OP_NOP;
		cmd.div_sel = DIV_BY_1000;
		in_stall    = 1'b1;
		unique case (state_q) inside
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = command ? OP_SYNC : OP_MUL;
				end
			end
			ST_DIV_MS: begin
				cmd.op      = OP_DIV;
				cmd.div_sel = DIV_BY_1000;
			end
			ST_LOAD_SEC: begin
				cmd.op = OP_LOAD_SEC;
			end
			ST_DIV_SEC, ST_DIV_MIN: begin
				cmd.op      = OP_DIV;
				cmd.div_sel = DIV_BY_60;
			end
			ST_SPLIT_SEC: begin
				cmd.op = OP_SPLIT_SEC;
			end
			ST_SPLIT_MIN: begin
				cmd.op = OP_SPLIT_MIN;
			end
			ST_DIV_HR: begin
				cmd.op      = OP_DIV;
				cmd.div_sel = DIV_BY_24;
			end
			ST_SPLIT_HR: begin
				cmd.op = OP_SPLIT_HR;
			end
			ST_WALK: begin
				cmd.op = OP_MONTH;
			end
			ST_PUB: begin
				if (slot_free) begin
					cmd.op = OP_PUBLISH;
				end
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.op == OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
